/* rtl/tbe_pkg.sv */
// ----------------------------------------------------------------------------
// Toeplitz block extractor package
// Shared constants, codes, cell control type and the per-cell fold function.
// ----------------------------------------------------------------------------
package tbe_pkg;

  localparam int BLOCK_BYTES_DEF = 64;
  localparam int OUT_BITS_DEF    = 256;
  localparam int SEED_BYTES_DEF  = 96;

  // Request codes.
  localparam logic REQ_SEED = 1'b0;
  localparam logic REQ_DATA = 1'b1;

  // Result status codes.
  localparam logic STAT_OK     = 1'b0;
  localparam logic STAT_REJECT = 1'b1;

  localparam int OUT_INDEX_W = 5;

  typedef struct packed {
    logic start;  // current data byte drops the partial block first
    logic shift;  // absorb: every cell takes its neighbor's folded byte
    logic clear;  // zero the accumulator without shifting
  } tbe_cell_ctl_t;

  // Parity of one data byte against a 16-bit seed window for the eight rows
  // of one output byte. Bit 7 of the result is the lowest-numbered row.
  function automatic logic [7:0] tbe_fold(input logic [7:0] raw, input logic [15:0] win);
    logic [7:0] res;
    res = '0;
    for (int t = 0; t < 8; t++) begin
      res[7-t] = ^(raw & win[15-t -: 8]);
    end
    return res;
  endfunction

endpackage

/* rtl/tbe_cell.sv */
// ----------------------------------------------------------------------------
// Toeplitz accumulator cell
// Holds one byte of parity rows and passes its folded value to the next cell.
// ----------------------------------------------------------------------------
module tbe_cell
  import tbe_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  tbe_cell_ctl_t ctl,
  input  logic [7:0]    raw_byte,
  input  logic [7:0]    seed_hi,
  input  logic [7:0]    seed_lo,
  input  logic [7:0]    shift_in,
  output logic [7:0]    fold_out
);

  logic [7:0] acc;
  logic [7:0] acc_eff;

  // A stream start means this byte sees an empty accumulator.
  assign acc_eff  = ctl.start ? 8'h00 : acc;
  assign fold_out = acc_eff ^ tbe_fold(raw_byte, {seed_hi, seed_lo});

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 8'h00;
    end else begin
      priority if (ctl.shift) begin
        acc <= shift_in;
      end else if (ctl.clear) begin
        acc <= 8'h00;
      end
    end
  end

endmodule

/* rtl/tbe_seed.sv */
// ----------------------------------------------------------------------------
// Toeplitz seed store
// Seed byte registers with per-byte written flags and a count of bytes loaded.
// ----------------------------------------------------------------------------
module tbe_seed
  import tbe_pkg::*;
#(
  parameter int SEED_BYTES = SEED_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic [6:0] wr_addr,
  input  logic [7:0] wr_data,
  output logic [7:0] seed [SEED_BYTES],
  output logic       full
);

  localparam int SA_W  = $clog2(SEED_BYTES);
  localparam int CNT_W = $clog2(SEED_BYTES + 1);

  logic [SEED_BYTES-1:0] written;
  logic [CNT_W-1:0]      count;
  logic                  in_range;
  logic [SA_W-1:0]       addr;

  assign in_range = 8'(wr_addr) < 8'(SEED_BYTES);
  assign addr     = SA_W'(wr_addr);
  assign full     = count == CNT_W'(SEED_BYTES);

  always_ff @(posedge clk) begin
    if (wr_en && in_range) begin
      seed[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      count   <= '0;
    end else if (wr_en && in_range && !written[addr]) begin
      written[addr] <= 1'b1;
      count         <= count + CNT_W'(1);
    end
  end

endmodule

/* rtl/tbe_obuf.sv */
// ----------------------------------------------------------------------------
// Toeplitz result buffer
// Holds one block's result bytes, or one reject, and drains one per transfer.
// ----------------------------------------------------------------------------
module tbe_obuf
  import tbe_pkg::*;
#(
  parameter int OUT_BYTES = OUT_BITS_DEF / 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load_blk,
  input  logic [7:0]             blk_bytes [OUT_BYTES],
  input  logic                   load_rej,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [7:0]             out_byte,
  output logic [OUT_INDEX_W-1:0] out_index,
  output logic                   last,
  output logic                   status,
  output logic                   free
);

  localparam int CNT_W  = $clog2(OUT_BYTES + 1);
  localparam int OIDX_W = (OUT_BYTES > 1) ? $clog2(OUT_BYTES) : 1;

  logic [7:0]        buf_q [OUT_BYTES];
  logic [CNT_W-1:0]  cnt;
  logic [OIDX_W-1:0] oidx;
  logic              stat;
  logic              xfer;

  assign out_valid = cnt != '0;
  assign xfer      = out_valid && out_ready;
  assign free      = (cnt == '0) || ((cnt == CNT_W'(1)) && out_ready);
  assign out_byte  = buf_q[0];
  assign out_index = OUT_INDEX_W'(oidx);
  assign status    = stat;
  assign last      = (cnt == CNT_W'(1)) && (stat == STAT_OK);

  always_ff @(posedge clk) begin
    if (load_blk) begin
      buf_q <= blk_bytes;
    end else if (load_rej) begin
      buf_q[0] <= 8'h00;
    end else if (xfer) begin
      for (int j = 0; j < OUT_BYTES - 1; j++) begin
        buf_q[j] <= buf_q[j+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      oidx <= '0;
      stat <= STAT_OK;
    end else begin
      priority if (load_blk) begin
        cnt  <= CNT_W'(OUT_BYTES);
        oidx <= '0;
        stat <= STAT_OK;
      end else if (load_rej) begin
        cnt  <= CNT_W'(1);
        oidx <= '0;
        stat <= STAT_REJECT;
      end else if (xfer) begin
        cnt  <= cnt - CNT_W'(1);
        oidx <= oidx + OIDX_W'(1);
      end
    end
  end

endmodule

/* rtl/toeplitz_block_extractor_unit.sv */
// ----------------------------------------------------------------------------
// Toeplitz block extractor
// Compresses blocks of raw entropy bytes into half-size Toeplitz hash output.
// ----------------------------------------------------------------------------
// The block takes one input item per clock cycle while in_ready is high. Seed
// loads are always taken at once. A data byte is folded into a row of
// accumulator cells in the cycle it is accepted; the accumulator shifts by one
// cell per absorbed byte, so the seed is only read at fixed taps. The byte that
// completes a block, and a byte rejected because the seed is incomplete, loads
// the result buffer, so it is taken only when that buffer is empty or its last
// byte is leaving in the same cycle. A block's result bytes drain one per cycle
// while the next block is absorbed, so with a steady consumer the input never stalls.
module toeplitz_block_extractor_unit
  import tbe_pkg::*;
#(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int OUT_BITS    = OUT_BITS_DEF,
  parameter int SEED_BYTES  = SEED_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   req_type,
  input  logic [6:0]             seed_index,
  input  logic [7:0]             seed_byte,
  input  logic [7:0]             raw_byte,
  input  logic                   stream_start,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic [OUT_INDEX_W-1:0] out_index,
  output logic                   last,
  output logic                   status
);

  localparam int OUT_BYTES = (OUT_BITS + 7) / 8;
  localparam int NCELL     = BLOCK_BYTES + OUT_BYTES - 1;
  localparam int POS_W     = $clog2(BLOCK_BYTES);
  localparam logic [7:0] LAST_MASK = 8'(8'hFF << (OUT_BYTES * 8 - OUT_BITS));

  logic [7:0]     seed_q   [SEED_BYTES];
  logic [7:0]     seed_win [NCELL+1];
  logic [7:0]     fold     [NCELL];
  logic [7:0]     blk_bytes [OUT_BYTES];
  logic           seed_full;
  logic           buf_free;
  logic           accept;
  logic           is_data;
  logic           start_eff;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_eff;
  logic           pos_end;
  logic           needs_out;
  logic           absorb;
  logic           complete;
  logic           reject;
  tbe_cell_ctl_t  ctl;

  assign is_data   = req_type == REQ_DATA;
  assign start_eff = is_data && stream_start;
  assign pos_eff   = start_eff ? '0 : pos;
  assign pos_end   = pos_eff == POS_W'(BLOCK_BYTES - 1);
  assign needs_out = is_data && (!seed_full || pos_end);
  assign in_ready  = !needs_out || buf_free;
  assign accept    = in_valid && in_ready;

  assign absorb   = accept && is_data && seed_full;
  assign complete = absorb && pos_end;
  assign reject   = accept && is_data && !seed_full;

  assign ctl.start = start_eff;
  assign ctl.shift = absorb && !complete;
  assign ctl.clear = complete || (accept && start_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept && is_data) begin
      if (complete) begin
        pos <= '0;
      end else if (seed_full) begin
        pos <= pos_eff + POS_W'(1);
      end else begin
        pos <= pos_eff;
      end
    end
  end

  tbe_seed #(
    .SEED_BYTES(SEED_BYTES)
  ) u_seed (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && (req_type == REQ_SEED)),
    .wr_addr (seed_index),
    .wr_data (seed_byte),
    .seed    (seed_q),
    .full    (seed_full)
  );

  // Seed bytes past the store read as zero.
  for (genvar i = 0; i < NCELL + 1; i++) begin : g_win
    if (i < SEED_BYTES) begin : g_in
      assign seed_win[i] = seed_q[i];
    end else begin : g_out
      assign seed_win[i] = 8'h00;
    end
  end

  // Cell c holds output byte c - pos of the current block.
  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    if (c == 0) begin : g_first
      tbe_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .raw_byte (raw_byte),
        .seed_hi  (seed_win[c]),
        .seed_lo  (seed_win[c+1]),
        .shift_in (8'h00),
        .fold_out (fold[c])
      );
    end else begin : g_rest
      tbe_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .raw_byte (raw_byte),
        .seed_hi  (seed_win[c]),
        .seed_lo  (seed_win[c+1]),
        .shift_in (fold[c-1]),
        .fold_out (fold[c])
      );
    end
  end

  // On the last byte of a block the finished rows sit in the upper cells.
  for (genvar b = 0; b < OUT_BYTES; b++) begin : g_blk
    if (b == OUT_BYTES - 1) begin : g_last
      assign blk_bytes[b] = fold[BLOCK_BYTES-1+b] & LAST_MASK;
    end else begin : g_mid
      assign blk_bytes[b] = fold[BLOCK_BYTES-1+b];
    end
  end

  tbe_obuf #(
    .OUT_BYTES(OUT_BYTES)
  ) u_obuf (
    .clk       (clk),
    .rst       (rst),
    .load_blk  (complete),
    .blk_bytes (blk_bytes),
    .load_rej  (reject),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_index (out_index),
    .last      (last),
    .status    (status),
    .free      (buf_free)
  );

endmodule
